/* rtl/sbp_pkg.sv */
// Shared types and constants for the six-button pad scan reader.
`default_nettype none

package sbp_pkg;

    localparam int unsigned PAD_LINES   = 6;
    localparam int unsigned NUM_BUTTONS = 12;
    localparam int unsigned BTN_W       = 4;
    localparam int unsigned WAIT_W      = 16;
    localparam int unsigned PHASE_W     = 3;

    localparam logic [WAIT_W-1:0] SCAN_WAIT_RESET = 16'd20;

    // Scan phases that act on the pad lines, and the final phase of a scan
    localparam logic [PHASE_W-1:0] PH_START_A = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIR_BC  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DETECT  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_XYZ     = 3'd5;
    localparam logic [PHASE_W-1:0] PH_LAST    = 3'd7;

    // Button indexes at the head of the A and Z groups
    localparam int unsigned BTN_A = 6;
    localparam int unsigned BTN_Z = 8;

    // Scan state: idle wait or running phases
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } scan_state_t;

    // Outcome of one sample tick, handed from the scan core to the event queue
    typedef struct packed {
        logic                   select_level;
        logic                   six_seen;
        logic [NUM_BUTTONS-1:0] pressed;
        logic [NUM_BUTTONS-1:0] changed;
    } scan_result_t;

endpackage

`default_nettype wire

/* rtl/sbp_scan_core.sv */
// Scan sequencer: wait counter, phase, pressed bits and the per-tick step logic.
`default_nettype none

module sbp_scan_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [sbp_pkg::WAIT_W-1:0]           cfg_data,
    input  wire logic                                 step_en,
    input  wire logic [sbp_pkg::PAD_LINES-1:0]        pad_lines,
    output sbp_pkg::scan_result_t                     result
);

    sbp_pkg::scan_state_t                   state_reg, state_next;
    logic [sbp_pkg::WAIT_W-1:0]             scan_wait_reg;
    logic [sbp_pkg::WAIT_W-1:0]             wait_count_reg, wait_count_next;
    logic [sbp_pkg::PHASE_W-1:0]            phase_reg, phase_next;
    logic [sbp_pkg::NUM_BUTTONS-1:0]        pressed_reg, pressed_next;
    logic                                   six_reg, six_next;
    logic                                   sel;
    logic [sbp_pkg::PAD_LINES-1:0]          low;

    // Pad lines are active low
    assign low = ~pad_lines;

    // Step logic for one sample tick
    always_comb begin
        state_next      = state_reg;
        wait_count_next = wait_count_reg;
        phase_next      = phase_reg;
        pressed_next    = pressed_reg;
        six_next        = six_reg;
        sel             = 1'b1;
        case (state_reg)
            sbp_pkg::ST_IDLE: begin
                if (wait_count_reg >= scan_wait_reg) begin
                    state_next      = sbp_pkg::ST_SCAN;
                    phase_next      = '0;
                    wait_count_next = '0;
                    sel             = 1'b0;
                end else begin
                    wait_count_next = wait_count_reg + sbp_pkg::WAIT_W'(1);
                    sel             = 1'b1;
                end
            end
            sbp_pkg::ST_SCAN: begin
                case (phase_reg)
                    sbp_pkg::PH_START_A: begin
                        if (low[2] && low[3]) begin
                            pressed_next[sbp_pkg::BTN_A+1:sbp_pkg::BTN_A] = low[5:4];
                        end
                    end
                    sbp_pkg::PH_DIR_BC: begin
                        pressed_next[5:0] = low[5:0];
                    end
                    sbp_pkg::PH_DETECT: begin
                        six_next = low[0] & low[1];
                    end
                    sbp_pkg::PH_XYZ: begin
                        if (six_reg) begin
                            pressed_next[sbp_pkg::BTN_Z+3:sbp_pkg::BTN_Z] = low[3:0];
                        end
                    end
                    default: begin
                    end
                endcase
                if (phase_reg == sbp_pkg::PH_LAST) begin
                    state_next      = sbp_pkg::ST_IDLE;
                    phase_next      = '0;
                    wait_count_next = '0;
                    sel             = 1'b1;
                end else begin
                    phase_next = phase_reg + sbp_pkg::PHASE_W'(1);
                    sel        = phase_next[0];
                end
            end
            default: begin
                state_next = sbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Hand the tick outcome to the event queue
    always_comb begin
        result.select_level = sel;
        result.six_seen     = six_next;
        result.pressed      = pressed_next;
        result.changed      = pressed_next ^ pressed_reg;
    end

    // Hold the scan state, advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbp_pkg::ST_IDLE;
            scan_wait_reg  <= sbp_pkg::SCAN_WAIT_RESET;
            wait_count_reg <= '0;
            phase_reg      <= '0;
            pressed_reg    <= '0;
            six_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                scan_wait_reg <= cfg_data;
            end
            if (step_en) begin
                state_reg      <= state_next;
                wait_count_reg <= wait_count_next;
                phase_reg      <= phase_next;
                pressed_reg    <= pressed_next;
                six_reg        <= six_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sbp_event_queue.sv */
// Result register that emits one change event per cycle unless stalled, lowest button first.
`default_nettype none

module sbp_event_queue (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               load,
    input  wire sbp_pkg::scan_result_t              result,
    output logic                                    free,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_select_level,
    output logic                                    m_has_event,
    output logic [sbp_pkg::BTN_W-1:0]               m_button,
    output logic                                    m_pressed,
    output logic                                    m_six_button_seen,
    output logic                                    m_last
);

    logic                               valid_reg;
    logic                               sel_reg;
    logic                               six_reg;
    logic [sbp_pkg::NUM_BUTTONS-1:0]    pressed_reg;
    logic [sbp_pkg::NUM_BUTTONS-1:0]    changed_reg;
    logic [sbp_pkg::NUM_BUTTONS-1:0]    rest;
    logic [sbp_pkg::BTN_W-1:0]          btn;

    // Pick the lowest pending change
    always_comb begin
        btn = '0;
        for (int i = sbp_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
            if (changed_reg[i]) begin
                btn = sbp_pkg::BTN_W'(i);
            end
        end
    end

    assign rest = changed_reg & ~(sbp_pkg::NUM_BUTTONS'(1) << btn);

    assign m_valid           = valid_reg;
    assign m_select_level    = sel_reg;
    assign m_six_button_seen = six_reg;
    assign m_has_event       = |changed_reg;
    assign m_button          = btn;
    assign m_pressed         = (|changed_reg) & pressed_reg[btn];
    assign m_last            = ~|rest;

    // Take a new item when empty or when the final result leaves now
    assign free = !valid_reg || (m_ready && m_last);

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready && m_last) begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload, drop each event as it is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            sel_reg     <= result.select_level;
            six_reg     <= result.six_seen;
            pressed_reg <= result.pressed;
            changed_reg <= result.changed;
        end else if (valid_reg && m_ready) begin
            changed_reg <= rest;
        end
    end

endmodule

`default_nettype wire

/* rtl/six_button_pad_scan_reader_unit.sv */
// Top level of the six-button pad scan reader.
//
// Usage: each item on the s_ channel is one sample tick carrying the six
// pad lines, sampled under the select level given by the previous result.
// Each item yields one or more results on the m_ channel: one per button
// whose state changed, in button index order, or a single result with
// m_has_event low when nothing changed. m_last marks the final result of
// an item. The cfg_ channel writes the idle wait in ticks; it is always
// ready, and the user must see that it is written only while the block
// is idle; the block itself does not enforce this. The first result of
// an item is valid the cycle after it is accepted. An item with n changes
// yields max(n,1) results (one to six). While m_ready is high, results
// leave one per cycle and the next item is accepted in the same cycle its
// predecessor's final result is taken; changeless items flow one per cycle.
// Reset: the block comes up idle with the wait count at zero, all buttons
// released, six-button flag clear and the wait set to 20 ticks.
// Stall: while m_ready is low a pending result holds and s_ready stays low.
`default_nettype none

module six_button_pad_scan_reader_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sbp_pkg::WAIT_W-1:0]         cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [sbp_pkg::PAD_LINES-1:0]      s_pad_lines,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_select_level,
    output logic                                    m_has_event,
    output logic [sbp_pkg::BTN_W-1:0]               m_button,
    output logic                                    m_pressed,
    output logic                                    m_six_button_seen,
    output logic                                    m_last
);

    sbp_pkg::scan_result_t  step_result;
    logic                   queue_free;
    logic                   accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = queue_free;
    assign accept    = s_valid && queue_free;

    sbp_scan_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step_en   (accept),
        .pad_lines (s_pad_lines),
        .result    (step_result)
    );

    sbp_event_queue u_queue (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (accept),
        .result            (step_result),
        .free              (queue_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_select_level    (m_select_level),
        .m_has_event       (m_has_event),
        .m_button          (m_button),
        .m_pressed         (m_pressed),
        .m_six_button_seen (m_six_button_seen),
        .m_last            (m_last)
    );

    // A result without an event is always the only one of its item
    a_no_event_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_event |-> m_last && m_button == '0 && !m_pressed)
        else $error("empty result not final or not cleared");

    // An empty result register always takes input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Taking a non-final result leaves more results of the same item
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_has_event)
        else $error("events lost after non-final result");

    // Input is never taken while a non-final result is pending
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted mid-item");

endmodule

`default_nettype wire
